FILE: rtl/core/chebyshev_3d_series_evaluator_assert.svh
// assertion macros for the chebyshev series evaluator
// expects clk_i and rst_ni in the scope of use
`ifndef CHEBYSHEV_3D_SERIES_EVALUATOR_ASSERT_SVH
`define CHEBYSHEV_3D_SERIES_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define CHEB3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHEB3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cheb3_pkg.sv
// shared constants, codes and rounding helpers for the chebyshev series evaluator
// no dependencies
package cheb3_pkg;

  localparam int unsigned TERMS_X = 16;
  localparam int unsigned TERMS_Y = 16;
  localparam int unsigned TERMS_Z = 16;

  localparam int unsigned T_MAX_XY = (TERMS_X > TERMS_Y) ? TERMS_X : TERMS_Y;
  localparam int unsigned T_MAX    = (T_MAX_XY > TERMS_Z) ? T_MAX_XY : TERMS_Z;
  localparam int unsigned TIDX_W   = (T_MAX > 1) ? $clog2(T_MAX) : 1;
  localparam int unsigned T_DEPTH  = 2 ** TIDX_W;

  localparam int unsigned COEF_AW    = 12;
  localparam int unsigned COEF_DEPTH = 2 ** COEF_AW;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ACC_W      = 52;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [2:0] CFG_X_LOW  = 3'd0;
  localparam logic [2:0] CFG_X_HIGH = 3'd1;
  localparam logic [2:0] CFG_Y_LOW  = 3'd2;
  localparam logic [2:0] CFG_Y_HIGH = 3'd3;
  localparam logic [2:0] CFG_Z_LOW  = 3'd4;
  localparam logic [2:0] CFG_Z_HIGH = 3'd5;

  localparam logic signed [31:0] Q30_ONE   = 32'sh4000_0000;
  localparam logic signed [31:0] Q16_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] Q16_M_ONE = -32'sh0001_0000;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_e;

  // floor((p + half ulp) / 2^30)
  function automatic logic signed [33:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd536870912;
    return s[63:30];
  endfunction

  // floor((2p + half ulp) / 2^30)
  function automatic logic signed [33:0] rnd_twice(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p <<< 1) + 64'sd536870912;
    return s[63:30];
  endfunction

  function automatic logic [TIDX_W-1:0] axis_last(input axis_e a);
    logic [TIDX_W-1:0] r;
    case (a)
      AX_X:    r = TIDX_W'(TERMS_X - 1);
      AX_Y:    r = TIDX_W'(TERMS_Y - 1);
      default: r = TIDX_W'(TERMS_Z - 1);
    endcase
    return r;
  endfunction

  function automatic logic axis_active(input axis_e a);
    logic r;
    case (a)
      AX_X:    r = (TERMS_X > 1);
      AX_Y:    r = (TERMS_Y > 1);
      default: r = (TERMS_Z > 1);
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/chebyshev_3d_series_evaluator.sv
// top level of the 3d chebyshev series evaluator
// depends on cheb3_pkg, cheb3_ram and chebyshev_3d_series_evaluator_assert.svh
//
//  channel  direction  handshake                 payload
//  in       in         in_valid_i / in_stall_o    kind, coef_index, coef_value, point_x/y/z
//  out      out        out_valid_o / out_stall_i  series_value, status
//  cfg      in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// a coefficient write word answers in the cycle after acceptance; an evaluate word
//   runs through the one shared 32x32 multiplier
//   and the bit-per-cycle divider that maps each coordinate
// a degenerate interval skips the divider of its axis
// reset clears the state machine and the output valid and sets each interval to [-1, 1]
// the next word is taken in idle once the result register is free or being drained
module chebyshev_3d_series_evaluator
  import cheb3_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [31:0]               cfg_data_i,
  // input words
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [COEF_AW-1:0]        coef_index_i,
  input  logic signed [31:0]        coef_value_i,
  input  logic signed [31:0]        point_x_i,
  input  logic signed [31:0]        point_y_i,
  input  logic signed [31:0]        point_z_i,
  // result words
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [31:0]        series_value_o,
  output logic [1:0]                status_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_BUILD,
    S_BSTORE,
    S_RD,
    S_WIJ,
    S_WRND,
    S_BAS,
    S_TERM,
    S_ACC,
    S_SAT,
    S_FIN
  } state_e;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-32'sh7fff_ffff - 32'sh1);

  state_e state_q;

  // interval registers
  logic signed [31:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q, z_lo_q, z_hi_q;

  // latched point and axis walk
  logic signed [31:0] px_q, py_q, pz_q;
  axis_e              ax_q;

  // divider
  logic [62:0]        dvd_q;
  logic [32:0]        rem_q;
  logic [32:0]        den_q;
  logic [30:0]        quo_q;
  logic               neg_q;
  logic [5:0]         cnt_q;

  // recurrence
  logic signed [31:0] t_q, prev1_q, prev2_q;
  logic [TIDX_W-1:0]  m_q;

  // series sum
  logic [TIDX_W-1:0]  i_q, j_q, k_q;
  logic [COEF_AW-1:0] addr_q;
  logic               last_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] wij_q;
  logic signed [ACC_W-1:0] acc_q;

  // result
  logic signed [31:0] res_val_q;
  logic [1:0]         res_st_q;
  logic               out_valid_q;
  logic signed [31:0] out_val_q;
  logic [1:0]         out_st_q;

  logic in_accept;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  // result register loads a new word this cycle
  logic out_load_d;
  assign out_load_d = (state_q == S_IDLE && in_accept && !kind_i) ||
                      (state_q == S_FIN && (!out_valid_q || !out_stall_i));

  // ---------------------------------------------------------------- memories
  logic [31:0] tx_rd, ty_rd, tz_rd, c_rd;
  logic        wr_en_d;
  logic [31:0] wr_val_d;

  cheb3_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
    .clk_i   (clk_i),
    .we_i    (in_accept && !kind_i),
    .waddr_i (coef_index_i),
    .wdata_i (coef_value_i),
    .raddr_i (addr_q),
    .rdata_o (c_rd)
  );

  cheb3_ram #(.WIDTH(32), .DEPTH(T_DEPTH)) u_tx (
    .clk_i   (clk_i),
    .we_i    (wr_en_d && (ax_q == AX_X)),
    .waddr_i (m_q),
    .wdata_i (wr_val_d),
    .raddr_i (i_q),
    .rdata_o (tx_rd)
  );

  cheb3_ram #(.WIDTH(32), .DEPTH(T_DEPTH)) u_ty (
    .clk_i   (clk_i),
    .we_i    (wr_en_d && (ax_q == AX_Y)),
    .waddr_i (m_q),
    .wdata_i (wr_val_d),
    .raddr_i (j_q),
    .rdata_o (ty_rd)
  );

  cheb3_ram #(.WIDTH(32), .DEPTH(T_DEPTH)) u_tz (
    .clk_i   (clk_i),
    .we_i    (wr_en_d && (ax_q == AX_Z)),
    .waddr_i (m_q),
    .wdata_i (wr_val_d),
    .raddr_i (k_q),
    .rdata_o (tz_rd)
  );

  // ---------------------------------------------------------- axis selection
  logic signed [31:0] lo_d, hi_d, p_d;
  always_comb begin
    case (ax_q)
      AX_X:    begin lo_d = x_lo_q; hi_d = x_hi_q; p_d = px_q; end
      AX_Y:    begin lo_d = y_lo_q; hi_d = y_hi_q; p_d = py_q; end
      default: begin lo_d = z_lo_q; hi_d = z_hi_q; p_d = pz_q; end
    endcase
  end

  logic               outside_d;
  logic signed [33:0] num_d;
  logic signed [32:0] den_d;
  logic [32:0]        mag_d;
  logic [62:0]        dvd_init_d;

  // t = (2p - hi - lo) / (hi - lo), rounded on the magnitude
  assign outside_d  = (p_d < lo_d) || (p_d > hi_d);
  assign num_d      = (34'(p_d) <<< 1) - 34'(hi_d) - 34'(lo_d);
  assign den_d      = 33'(hi_d) - 33'(lo_d);
  assign mag_d      = num_d[33] ? 33'(-num_d) : 33'(num_d);
  assign dvd_init_d = {mag_d, 30'd0} + 63'(den_d[32:1]);

  // one restoring step per cycle
  logic [33:0] rem_sh_d, rem_nx_d;
  logic        qbit_d;
  logic [30:0] quo_fin_d;
  assign rem_sh_d  = {rem_q, dvd_q[62]};
  assign qbit_d    = (rem_sh_d >= {1'b0, den_q});
  assign rem_nx_d  = qbit_d ? (rem_sh_d - {1'b0, den_q}) : rem_sh_d;
  assign quo_fin_d = {quo_q[29:0], qbit_d};

  // ----------------------------------------------------- shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d;
  logic signed [33:0] basis_d;
  assign basis_d = rnd_q30(prod_q);

  always_comb begin
    case (state_q)
      S_WIJ:   begin mul_a = tx_rd;  mul_b = ty_rd;  end
      S_BAS:   begin mul_a = wij_q;  mul_b = tz_rd;  end
      S_TERM:  begin mul_a = c_rd;   mul_b = basis_d[31:0]; end
      default: begin mul_a = t_q;    mul_b = prev1_q; end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // recurrence update, clamped to [-1, 1]
  logic signed [34:0] diff_d;
  logic signed [31:0] clamp_d;
  assign diff_d = 35'(rnd_twice(prod_q)) - 35'(prev2_q);
  always_comb begin
    if (diff_d > 35'(Q30_ONE)) begin
      clamp_d = Q30_ONE;
    end else if (diff_d < -35'(Q30_ONE)) begin
      clamp_d = -Q30_ONE;
    end else begin
      clamp_d = diff_d[31:0];
    end
  end

  // table writes while building T_n
  logic m_low_d;
  assign m_low_d = (m_q == '0) || (m_q == TIDX_W'(1));
  always_comb begin
    wr_en_d  = 1'b0;
    wr_val_d = clamp_d;
    if (state_q == S_BUILD && m_low_d) begin
      wr_en_d  = 1'b1;
      wr_val_d = (m_q == '0) ? Q30_ONE : t_q;
    end else if (state_q == S_BSTORE) begin
      wr_en_d  = 1'b1;
    end
  end

  logic m_last_d;
  assign m_last_d = (m_q == axis_last(ax_q));

  // --------------------------------------------------------- control and data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      x_lo_q      <= Q16_M_ONE;
      x_hi_q      <= Q16_ONE;
      y_lo_q      <= Q16_M_ONE;
      y_hi_q      <= Q16_ONE;
      z_lo_q      <= Q16_M_ONE;
      z_hi_q      <= Q16_ONE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_X_LOW:  x_lo_q <= cfg_data_i;
          CFG_X_HIGH: x_hi_q <= cfg_data_i;
          CFG_Y_LOW:  y_lo_q <= cfg_data_i;
          CFG_Y_HIGH: y_hi_q <= cfg_data_i;
          CFG_Z_LOW:  z_lo_q <= cfg_data_i;
          CFG_Z_HIGH: z_hi_q <= cfg_data_i;
          default: ;
        endcase
      end

      // drained word leaves unless a new one takes its place
      if (out_valid_q && !out_stall_i && !out_load_d) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (!kind_i) begin
              // coefficient write answers at once
              out_valid_q <= 1'b1;
              out_val_q   <= '0;
              out_st_q    <= ST_OK;
            end else begin
              px_q    <= point_x_i;
              py_q    <= point_y_i;
              pz_q    <= point_z_i;
              ax_q    <= AX_X;
              i_q     <= '0;
              j_q     <= '0;
              k_q     <= '0;
              addr_q  <= '0;
              last_q  <= 1'b0;
              acc_q   <= '0;
              state_q <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          m_q <= '0;
          if (axis_active(ax_q) && outside_d) begin
            res_val_q <= '0;
            res_st_q  <= ST_RANGE;
            state_q   <= S_FIN;
          end else if (!axis_active(ax_q) || den_d <= 33'sd0) begin
            // single-term axis or degenerate interval
            t_q     <= '0;
            state_q <= S_BUILD;
          end else begin
            dvd_q   <= dvd_init_d;
            rem_q   <= '0;
            quo_q   <= '0;
            den_q   <= den_d;
            neg_q   <= num_d[33];
            cnt_q   <= 6'd62;
            state_q <= S_DIV;
          end
        end

        S_DIV: begin
          dvd_q <= {dvd_q[61:0], 1'b0};
          rem_q <= rem_nx_d[32:0];
          quo_q <= quo_fin_d;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            t_q     <= neg_q ? -$signed({1'b0, quo_fin_d}) : $signed({1'b0, quo_fin_d});
            state_q <= S_BUILD;
          end
        end

        S_BUILD: begin
          if (m_low_d) begin
            prev2_q <= prev1_q;
            prev1_q <= wr_val_d;
            if (m_last_d) begin
              if (ax_q == AX_Z) begin
                state_q <= S_RD;
              end else begin
                ax_q    <= axis_e'(ax_q + 2'd1);
                state_q <= S_CHECK;
              end
            end else begin
              m_q <= m_q + TIDX_W'(1);
            end
          end else begin
            prod_q  <= prod_d;
            state_q <= S_BSTORE;
          end
        end

        S_BSTORE: begin
          prev2_q <= prev1_q;
          prev1_q <= clamp_d;
          if (m_last_d) begin
            if (ax_q == AX_Z) begin
              state_q <= S_RD;
            end else begin
              ax_q    <= axis_e'(ax_q + 2'd1);
              state_q <= S_CHECK;
            end
          end else begin
            m_q     <= m_q + TIDX_W'(1);
            state_q <= S_BUILD;
          end
        end

        // table reads settle after the last build write
        S_RD: state_q <= S_WIJ;

        S_WIJ: begin
          prod_q  <= prod_d;
          state_q <= S_WRND;
        end

        S_WRND: begin
          wij_q   <= basis_d[31:0];
          state_q <= S_BAS;
        end

        S_BAS: begin
          prod_q  <= prod_d;
          state_q <= S_TERM;
        end

        S_TERM: begin
          prod_q <= prod_d;
          addr_q <= addr_q + COEF_AW'(1);
          if (k_q == axis_last(AX_Z)) begin
            k_q <= '0;
            if (j_q == axis_last(AX_Y)) begin
              j_q <= '0;
              if (i_q == axis_last(AX_X)) begin
                last_q <= 1'b1;
              end else begin
                i_q <= i_q + TIDX_W'(1);
              end
            end else begin
              j_q <= j_q + TIDX_W'(1);
            end
          end else begin
            k_q <= k_q + TIDX_W'(1);
          end
          state_q <= S_ACC;
        end

        S_ACC: begin
          acc_q <= acc_q + ACC_W'(basis_d);
          if (last_q) begin
            state_q <= S_SAT;
          end else if (k_q == '0) begin
            state_q <= S_WIJ;
          end else begin
            state_q <= S_BAS;
          end
        end

        S_SAT: begin
          if (acc_q > ACC_MAX) begin
            res_val_q <= 32'sh7fff_ffff;
            res_st_q  <= ST_SAT;
          end else if (acc_q < ACC_MIN) begin
            res_val_q <= -32'sh7fff_ffff - 32'sh1;
            res_st_q  <= ST_SAT;
          end else begin
            res_val_q <= acc_q[31:0];
            res_st_q  <= ST_OK;
          end
          state_q <= S_FIN;
        end

        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign series_value_o = out_val_q;
  assign status_o       = out_st_q;

  // ---------------------------------------------------------------- checks
`include "chebyshev_3d_series_evaluator_assert.svh"

  `CHEB3_ASSERT_NXT(a_busy_after_eval, in_valid_i && !in_stall_o && kind_i, in_stall_o, "evaluate word did not hold off input")
  `CHEB3_ASSERT_NOW(a_range_zero, out_valid_o && status_o == ST_RANGE, series_value_o == '0, "range error with nonzero value")
  `CHEB3_ASSERT_NOW(a_sat_limit, out_valid_o && status_o == ST_SAT, series_value_o == 32'h7fff_ffff || series_value_o == 32'h8000_0000, "saturated value not at a limit")

endmodule

FILE: rtl/core/cheb3_ram.sv
// generic single write port ram with registered read
// no dependencies
module cheb3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/cheb3_tb_pkg.sv
// word kinds shared by the bench checker and the bench top
// no dependencies
package cheb3_tb_pkg;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

endpackage

FILE: bench/cheb3_series_checker.sv
// watches the channels of the chebyshev evaluator, predicts each result word and compares
// depends on cheb3_pkg and cheb3_tb_pkg
module cheb3_series_checker
  import cheb3_pkg::*;
  import cheb3_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               kind_i,
  input  logic [COEF_AW-1:0] coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] series_value_i,
  input  logic [1:0]         status_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } series_word_t;

  localparam longint Q30 = longint'(1) << 30;
  localparam longint HALF = longint'(1) << 29;

  logic signed [31:0] coef_mirror [COEF_DEPTH];
  logic signed [31:0] bound [6];
  series_word_t       expected_q [$];

  function automatic longint rnd_mul(longint a, longint b);
    return (a * b + HALF) >>> 30;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > Q30) return Q30;
    if (v < -Q30) return -Q30;
    return v;
  endfunction

  // rounds to nearest, ties away from zero
  function automatic longint to_unit(longint p, longint lo, longint hi);
    longint num, den;
    longint unsigned mag, q;
    num = 2 * p - hi - lo;
    den = hi - lo;
    if (den <= 0) return 0;
    mag = (num < 0) ? -num : num;
    q = ((mag << 30) + longint'(den) / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void cheb_basis(longint t, int n, ref longint tp [T_MAX]);
    tp[0] = Q30;
    if (n > 1) tp[1] = t;
    for (int m = 2; m < n; m++)
      tp[m] = unit_clamp(((2 * t * tp[m-1] + HALF) >>> 30) - tp[m-2]);
  endfunction

  function automatic series_word_t series_at(longint px, longint py, longint pz);
    series_word_t r;
    longint tx [T_MAX];
    longint ty [T_MAX];
    longint tz [T_MAX];
    longint sum, wij;
    int addr;
    r = '{value: '0, status: ST_OK};
    if (px < bound[CFG_X_LOW] || px > bound[CFG_X_HIGH]) begin
      r.status = ST_RANGE;
      return r;
    end
    if (TERMS_Y > 1 && (py < bound[CFG_Y_LOW] || py > bound[CFG_Y_HIGH])) begin
      r.status = ST_RANGE;
      return r;
    end
    if (TERMS_Z > 1 && (pz < bound[CFG_Z_LOW] || pz > bound[CFG_Z_HIGH])) begin
      r.status = ST_RANGE;
      return r;
    end
    cheb_basis(to_unit(px, bound[CFG_X_LOW], bound[CFG_X_HIGH]), TERMS_X, tx);
    cheb_basis(TERMS_Y > 1 ? to_unit(py, bound[CFG_Y_LOW], bound[CFG_Y_HIGH]) : 0,
               TERMS_Y, ty);
    cheb_basis(TERMS_Z > 1 ? to_unit(pz, bound[CFG_Z_LOW], bound[CFG_Z_HIGH]) : 0,
               TERMS_Z, tz);
    sum = 0;
    addr = 0;
    for (int i = 0; i < TERMS_X; i++)
      for (int j = 0; j < TERMS_Y; j++) begin
        wij = rnd_mul(tx[i], ty[j]);
        for (int k = 0; k < TERMS_Z; k++) begin
          sum += rnd_mul(longint'(coef_mirror[addr % COEF_DEPTH]), rnd_mul(wij, tz[k]));
          addr++;
        end
      end
    if (sum > 64'sh7fff_ffff) begin
      sum = 64'sh7fff_ffff;
      r.status = ST_SAT;
    end else if (sum < -64'sh8000_0000) begin
      sum = -64'sh8000_0000;
      r.status = ST_SAT;
    end
    r.value = sum[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    series_word_t got, want;
    if (!rst_ni) begin
      bound[CFG_X_LOW]  = Q16_M_ONE;
      bound[CFG_X_HIGH] = Q16_ONE;
      bound[CFG_Y_LOW]  = Q16_M_ONE;
      bound[CFG_Y_HIGH] = Q16_ONE;
      bound[CFG_Z_LOW]  = Q16_M_ONE;
      bound[CFG_Z_HIGH] = Q16_ONE;
      errors_o = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= CFG_Z_HIGH)
        bound[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KIND_WRITE) begin
          coef_mirror[coef_index_i] = coef_value_i;
          expected_q.push_back('{value: '0, status: ST_OK});
        end else begin
          expected_q.push_back(series_at(point_x_i, point_y_i, point_z_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{value: series_value_i, status: status_i};
        if (expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("result word with nothing expected: value %h status %0d",
                     got.value, got.status);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: value %h (want %h) status %0d (want %0d)",
                       got.value, want.value, got.status, want.status);
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

FILE: bench/testbench.sv
// stimulus and verdict for the chebyshev 3d series evaluator
// depends on cheb3_pkg, cheb3_tb_pkg, cheb3_series_checker and the rtl
module testbench;
  import cheb3_pkg::*;
  import cheb3_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 8_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               kind_i = KIND_WRITE;
  logic [COEF_AW-1:0] coef_index_i = '0;
  logic signed [31:0] coef_value_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] point_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] series_value_o;
  logic [1:0]         status_o;

  int     errors;
  int     pending;
  longint cycles = 0;
  int     burst_left = 0;
  int     n_writes = 0;
  int     n_evals = 0;
  int     n_cfg = 0;
  logic signed [31:0] lim [6];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  chebyshev_3d_series_evaluator u_top (.*);

  cheb3_series_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .coef_index_i, .coef_value_i,
    .point_x_i, .point_y_i, .point_z_i,
    .out_valid_i(out_valid_o), .out_stall_i, .series_value_i(series_value_o),
    .status_i(status_o), .errors_o(errors), .pending_o(pending)
  );

  // watchdog, sized for a full run of slow evaluate words under heavy stalls
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls: alternate windows of random stall density and clear stretches
  always @(negedge clk_i) begin
    int mode;
    if (cycles % 200 == 0) mode = $urandom_range(0, 3);
    case (mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // one word on the input channel; valid stays up inside a burst
  task automatic send_word(logic kind, logic [COEF_AW-1:0] idx, logic signed [31:0] coef,
                           logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i   = 1'b1;
    kind_i       = kind;
    coef_index_i = idx;
    coef_value_i = coef;
    point_x_i    = px;
    point_y_i    = py;
    point_z_i    = pz;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (burst_left == 0) in_valid_i = 1'b0;
    if (kind == KIND_WRITE) n_writes++;
    else n_evals++;
  endtask

  task automatic write_coef(int idx, logic signed [31:0] v);
    send_word(KIND_WRITE, COEF_AW'(idx), v, $urandom, $urandom, $urandom);
  endtask

  task automatic eval_at(logic signed [31:0] px, logic signed [31:0] py,
                         logic signed [31:0] pz);
    send_word(KIND_EVAL, COEF_AW'($urandom), $urandom, px, py, pz);
  endtask

  // coefficient of mixed magnitude so that some sums stay in range
  function automatic logic signed [31:0] mixed_coef();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(6, 31);
  endfunction

  // every entry once, all small enough that single large entries decide saturation
  task automatic fill_store();
    for (int a = 0; a < COEF_DEPTH; a++)
      write_coef(a, mixed_coef());
  endtask

  // registers change only with the block idle
  task automatic set_reg(logic [2:0] idx, logic signed [31:0] v);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    lim[idx]   = v;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    n_cfg++;
  endtask

  task automatic set_axis(logic [2:0] lo_idx, logic signed [31:0] lo, logic signed [31:0] hi);
    set_reg(lo_idx, lo);
    set_reg(lo_idx + 3'd1, hi);
  endtask

  // random interval: usually a sane span, sometimes the full range or reversed
  task automatic random_axis(logic [2:0] lo_idx);
    longint lo, hi;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      lo = -64'sh8000_0000;
      hi = 64'sh7fff_ffff;
    end else begin
      lo = longint'($signed($urandom)) >>> $urandom_range(0, 12);
      hi = lo + ($urandom >> $urandom_range(0, 20));
      if (hi > 64'sh7fff_ffff) hi = 64'sh7fff_ffff;
    end
    if (pick == 1) set_axis(lo_idx, 32'(hi), 32'(lo));
    else set_axis(lo_idx, 32'(lo), 32'(hi));
  endtask

  // coordinate mostly inside the current interval of that axis
  function automatic logic signed [31:0] coord(logic [2:0] lo_idx);
    longint lo, hi;
    longint unsigned span;
    lo = lim[lo_idx];
    hi = lim[lo_idx + 3'd1];
    if (hi < lo || $urandom_range(0, 19) == 0) return $urandom;
    case ($urandom_range(0, 9))
      0:       return 32'(lo);
      1:       return 32'(hi);
      default: begin
        span = hi - lo + 1;
        return 32'(lo + longint'({$urandom, $urandom} % span));
      end
    endcase
  endfunction

  initial begin
    lim = '{Q16_M_ONE, Q16_ONE, Q16_M_ONE, Q16_ONE, Q16_M_ONE, Q16_ONE};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    fill_store();

    // at x = y = 0 the first two entries weigh 1 and T_1(z)
    write_coef(0, 32'sh7fff_ffff);
    write_coef(1, 32'sh7fff_ffff);
    eval_at(32'sh0, 32'sh0, Q16_ONE);      // both add: saturates upward
    eval_at(32'sh0, 32'sh0, Q16_M_ONE);    // the two cancel
    write_coef(0, -32'sh8000_0000);
    eval_at(32'sh0, 32'sh0, Q16_M_ONE);    // both subtract: saturates downward
    write_coef(1, mixed_coef());

    // directed: extreme entries, corners, center and each coordinate outside
    write_coef(0, 32'sh7fff_ffff);
    write_coef(COEF_DEPTH - 1, -32'sh8000_0000);
    eval_at(32'sh0, 32'sh0, 32'sh0);
    eval_at(Q16_ONE, Q16_M_ONE, Q16_ONE);
    eval_at(Q16_M_ONE - 1, 32'sh0, 32'sh0);
    eval_at(32'sh0, Q16_ONE + 1, 32'sh0);
    eval_at(32'sh0, 32'sh0, -32'sh8000_0000);
    eval_at(32'sh7fff_ffff, 32'sh0, 32'sh0);
    write_coef(0, mixed_coef());
    write_coef(COEF_DEPTH - 1, mixed_coef());

    // degenerate x interval: only the one point maps, to t of zero
    set_axis(CFG_X_LOW, 32'sh5, 32'sh5);
    eval_at(32'sh5, 32'sh8000, -32'sh8000);
    eval_at(32'sh4, 32'sh0, 32'sh0);
    // reversed interval rejects everything
    set_axis(CFG_Y_LOW, Q16_ONE, Q16_M_ONE);
    eval_at(32'sh5, 32'sh0, 32'sh0);
    // widest intervals, points at their ends
    set_axis(CFG_X_LOW, -32'sh8000_0000, 32'sh7fff_ffff);
    set_axis(CFG_Y_LOW, -32'sh8000_0000, 32'sh7fff_ffff);
    set_axis(CFG_Z_LOW, -32'sh8000_0000, 32'sh7fff_ffff);
    eval_at(-32'sh8000_0000, 32'sh7fff_ffff, -32'sh8000_0000);
    eval_at(32'sh7fff_ffff, -32'sh8000_0000, 32'sh7fff_ffff);
    eval_at(32'sh1234_5678, -32'sh0edc_ba98, 32'sh0);

    // random words in three phases, fresh intervals per phase
    for (int ph = 0; ph < 3; ph++) begin
      random_axis(CFG_X_LOW);
      random_axis(CFG_Y_LOW);
      random_axis(CFG_Z_LOW);
      for (int n = 0; n < 35; n++)
        if ($urandom_range(0, 9) < 3) eval_at(coord(CFG_X_LOW), coord(CFG_Y_LOW),
                                              coord(CFG_Z_LOW));
        else write_coef($urandom_range(0, COEF_DEPTH - 1),
                        ($urandom_range(0, 9) == 0) ? $urandom : mixed_coef());
    end

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("covered %0d coefficient writes, %0d evaluations, %0d register writes",
             n_writes, n_evals, n_cfg);
    $display("including saturation both ways, out-of-interval, degenerate and full-range axes");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
